>>> hw/rtl/urhb_pkg.sv
// Shared types, constants and helpers for the undo/redo history buffer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package urhb_pkg;

  localparam int HISTORY_DEPTH   = 64;
  localparam int SLOT_W          = $clog2(HISTORY_DEPTH);
  localparam int CNT_W           = $clog2(HISTORY_DEPTH + 1);
  localparam int UNDO_MIN_CURSOR = 2;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] WINDOW_RESET = 16'd500;

  localparam logic [2:0] CMD_CAPTURE = 3'd0;
  localparam logic [2:0] CMD_PRECAP  = 3'd1;
  localparam logic [2:0] CMD_UNDO    = 3'd2;
  localparam logic [2:0] CMD_REDO    = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;
  localparam logic [2:0] CMD_MARK    = 3'd5;

  typedef enum logic [2:0] {
    OP_CAPTURE,
    OP_PRECAP,
    OP_UNDO,
    OP_REDO,
    OP_CLEAR,
    OP_MARK,
    OP_STATUS
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] snapshot_ref;
    logic [15:0] selected_index;
    logic [31:0] coalesce_key;
    logic [31:0] now_ticks;
    logic        suspended;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] restored_ref;
    logic [15:0] restored_index;
    logic        can_undo;
    logic        can_redo;
    logic        at_saved;
    logic        live_ahead;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] snapshot_ref;
    logic [15:0] selected_index;
    logic [31:0] coalesce_key;
    logic [31:0] now_ticks;
  } work_t;

  // Physical slot of logical entry idx; base < depth and idx < depth.
  function automatic logic [SLOT_W-1:0] slot_of(logic [SLOT_W-1:0] base,
                                                 logic [CNT_W-1:0]  idx);
    logic [CNT_W:0] sum;
    logic [CNT_W:0] adj;
    sum = {{(CNT_W + 1 - SLOT_W){1'b0}}, base} + {1'b0, idx};
    adj = (sum >= (CNT_W + 1)'(HISTORY_DEPTH)) ? sum - (CNT_W + 1)'(HISTORY_DEPTH) : sum;
    return adj[SLOT_W-1:0];
  endfunction

endpackage

>>> hw/rtl/urhb_front.sv
// Front end: takes input transfers and classifies each command into an op.
// Depends on urhb_pkg.
`timescale 1ns / 1ps

module urhb_front import urhb_pkg::*; (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push_valid,
  output work_t    push_work
);

  op_t op;

  always_comb begin
    unique case (in_data.command)
      CMD_CAPTURE: op = in_data.suspended ? OP_STATUS : OP_CAPTURE;
      CMD_PRECAP:  op = in_data.suspended ? OP_STATUS : OP_PRECAP;
      CMD_UNDO:    op = OP_UNDO;
      CMD_REDO:    op = OP_REDO;
      CMD_CLEAR:   op = OP_CLEAR;
      CMD_MARK:    op = OP_MARK;
      default:     op = OP_STATUS;
    endcase
  end

  assign in_ready   = !q_full;
  assign push_valid = in_valid && !q_full;

  always_comb begin
    push_work.op             = op;
    push_work.snapshot_ref   = in_data.snapshot_ref;
    push_work.selected_index = in_data.selected_index;
    push_work.coalesce_key   = in_data.coalesce_key;
    push_work.now_ticks      = in_data.now_ticks;
  end

endmodule

>>> hw/rtl/urhb_queue.sv
// Short FIFO of classified commands between front and back end.
// Depends on urhb_pkg.
`timescale 1ns / 1ps

module urhb_queue import urhb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  work_t push_work,
  output logic  q_full,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_work
);

  work_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign q_full    = fill == QCNT_W'(QUEUE_DEPTH);
  assign pop_valid = fill != '0;
  assign pop_work  = entries[rd_ptr];
  assign do_push   = push_valid && !q_full;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/urhb_back.sv
// Back end: history ring memories, cursor state, command execution and
// the result register. Depends on urhb_pkg.
`timescale 1ns / 1ps

module urhb_back import urhb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  work_t       pop_work,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic [47:0] data_mem [HISTORY_DEPTH];
  logic [63:0] meta_mem [HISTORY_DEPTH];
  logic [47:0] data_rd;
  logic [63:0] meta_rd;

  back_state_t state;
  back_state_t state_next;
  work_t       work;

  logic [15:0]              window;
  logic [HISTORY_DEPTH-1:0] marks;
  logic [HISTORY_DEPTH-1:0] marks_next;
  logic [SLOT_W-1:0]        oldest;
  logic [SLOT_W-1:0]        oldest_next;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  logic [CNT_W-1:0]         cur;
  logic [CNT_W-1:0]         cur_next;
  logic                     ahead;
  logic                     ahead_next;

  logic              rd_en;
  logic [SLOT_W-1:0] rd_slot;
  logic              exec_fire;
  logic              data_we;
  logic              meta_we;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] tail_slot;
  logic              match;
  logic [31:0]       tick_gap;
  logic              full;
  logic [SLOT_W-1:0] push_base;
  logic [CNT_W-1:0]  push_pos;
  logic [SLOT_W-1:0] push_slot;
  logic              acc;
  logic [31:0]       rref;
  logic [15:0]       ridx;
  logic              saved;

  // Control sequencing
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (pop_valid) state_next = BK_EXEC;
      BK_EXEC: if (!out_valid || out_ready) state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    rd_en     = 1'b0;
    exec_fire = 1'b0;
    unique case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        rd_en     = pop_valid;
      end
      BK_EXEC: exec_fire = !out_valid || out_ready;
    endcase
  end

  always_comb begin
    unique case (pop_work.op)
      OP_UNDO: rd_slot = slot_of(oldest, cur - CNT_W'(2));
      OP_REDO: rd_slot = slot_of(oldest, cur);
      default: rd_slot = slot_of(oldest, cur - CNT_W'(1));
    endcase
  end

  // Entry memories
  always_ff @(posedge clk) begin
    if (data_we && exec_fire) begin
      data_mem[wr_slot] <= {work.snapshot_ref, work.selected_index};
    end
    if (meta_we && exec_fire) begin
      meta_mem[wr_slot] <= {work.coalesce_key, work.now_ticks};
    end
    if (rd_en) begin
      data_rd <= data_mem[rd_slot];
      meta_rd <= meta_mem[rd_slot];
    end
  end

  // Execution
  assign tail_slot = slot_of(oldest, cur - CNT_W'(1));
  assign tick_gap  = work.now_ticks - meta_rd[31:0];
  assign match     = (work.coalesce_key != '0) && (cur != '0) &&
                     (meta_rd[63:32] == work.coalesce_key) && (tick_gap <= {16'd0, window});
  assign full      = cur >= CNT_W'(HISTORY_DEPTH);
  assign push_base = !full ? oldest :
                     (oldest == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : oldest + SLOT_W'(1);
  assign push_pos  = full ? CNT_W'(HISTORY_DEPTH - 1) : cur;
  assign push_slot = slot_of(push_base, push_pos);

  always_comb begin
    cur_next    = cur;
    cnt_next    = cnt;
    oldest_next = oldest;
    ahead_next  = ahead;
    marks_next  = marks;
    data_we     = 1'b0;
    meta_we     = 1'b0;
    wr_slot     = tail_slot;
    acc         = 1'b0;
    rref        = '0;
    ridx        = '0;
    unique case (work.op)
      OP_CAPTURE, OP_PRECAP: begin
        ahead_next = 1'b1;
        if (work.op == OP_CAPTURE && match) begin
          cnt_next              = cur;
          data_we               = 1'b1;
          meta_we               = 1'b1;
          marks_next[tail_slot] = 1'b0;
        end else if (work.op == OP_PRECAP && cur == cnt && match) begin
          meta_we = 1'b1;
        end else begin
          oldest_next           = push_base;
          cnt_next              = push_pos + CNT_W'(1);
          cur_next              = push_pos + CNT_W'(1);
          wr_slot               = push_slot;
          data_we               = 1'b1;
          meta_we               = 1'b1;
          marks_next[push_slot] = 1'b0;
          acc                   = 1'b1;
        end
      end
      OP_UNDO: begin
        if (cur >= CNT_W'(UNDO_MIN_CURSOR)) begin
          ahead_next = 1'b0;
          cur_next   = cur - CNT_W'(1);
          {rref, ridx} = data_rd;
          acc        = 1'b1;
        end
      end
      OP_REDO: begin
        if (cur < cnt) begin
          ahead_next = 1'b0;
          cur_next   = cur + CNT_W'(1);
          {rref, ridx} = data_rd;
          acc        = 1'b1;
        end
      end
      OP_CLEAR: begin
        cur_next    = '0;
        cnt_next    = '0;
        oldest_next = '0;
        ahead_next  = 1'b0;
        marks_next  = '0;
      end
      OP_MARK: begin
        if (cnt != '0) begin
          marks_next = '0;
          if (cur != '0) marks_next[tail_slot] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign saved = (cur_next != '0) && marks_next[slot_of(oldest_next, cur_next - CNT_W'(1))];

  // Registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      work <= pop_work;
    end
    if (exec_fire) begin
      out_data.accepted       <= acc;
      out_data.restored_ref   <= rref;
      out_data.restored_index <= ridx;
      out_data.can_undo       <= cur_next >= CNT_W'(UNDO_MIN_CURSOR);
      out_data.can_redo       <= cur_next < cnt_next;
      out_data.at_saved       <= saved;
      out_data.live_ahead     <= ahead_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      window    <= WINDOW_RESET;
      marks     <= '0;
      oldest    <= '0;
      cnt       <= '0;
      cur       <= '0;
      ahead     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) window <= cfg_wdata;
      if (exec_fire) begin
        marks     <= marks_next;
        oldest    <= oldest_next;
        cnt       <= cnt_next;
        cur       <= cur_next;
        ahead     <= ahead_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/undo_redo_history_buffer.sv
// Top level of the undo/redo history buffer: front end, command queue, back end.
// Depends on urhb_pkg, urhb_front, urhb_queue, urhb_back.
//
// Usage:
//   Commands arrive on in_valid/in_ready/in_data; each transfer yields exactly
//   one result on out_valid/out_ready/out_data, in order.
//   cfg_we/cfg_wdata write the coalesce window at any edge; write it only
//   while no command is in flight.
//   Flow: a command reaches the back end through a two-entry queue; the
//   back end reads the entry memory in BK_IDLE and executes the command in
//   BK_EXEC, where the result register is loaded.
//   The back end takes a new command only after the previous one has
//   executed; it never reads one command while executing another.
//   When the receiver stalls, the result register holds; the back end waits
//   with its next command read, and the queue keeps accepting until full.
//   Reset (rst, synchronous) empties the history, clears saved marks, sets the
//   window to 500 ticks and drops queued commands.
`timescale 1ns / 1ps

module undo_redo_history_buffer import urhb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic  q_full;
  logic  push_valid;
  work_t push_work;
  logic  pop_valid;
  logic  pop_ready;
  work_t pop_work;

  urhb_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_work  (push_work)
  );

  urhb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_work  (push_work),
    .q_full     (q_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_work   (pop_work)
  );

  urhb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_work  (pop_work),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/urhb_checker.sv
// Port-level checks on the result channel of the history buffer, bound to the top.
// Depends on urhb_pkg and undo_redo_history_buffer.
`timescale 1ns / 1ps

module urhb_checker import urhb_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_restore_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.accepted |-> out_data.restored_ref == '0 &&
                                        out_data.restored_index == '0)
    else $error("restored fields set without success");

  a_push_at_tip: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted && out_data.live_ahead |-> !out_data.can_redo)
    else $error("push left a redo branch");

endmodule

bind undo_redo_history_buffer urhb_checker u_urhb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> test/urhb_history_checker.sv
// Checker for the undo/redo history buffer: predicts every result from the transfers it
// observes, compares each result field by field and reports the mismatch and pending counts.
// Depends on urhb_pkg.
`timescale 1ns / 1ps

module urhb_history_checker import urhb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending_count
);

  localparam int EXP_DEPTH = 16;

  logic [31:0]              snap_mem  [HISTORY_DEPTH];
  logic [15:0]              sel_mem   [HISTORY_DEPTH];
  logic [31:0]              key_mem   [HISTORY_DEPTH];
  logic [31:0]              stamp_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] saved_mark;
  int unsigned              ring_base;
  int unsigned              n_entries;
  int unsigned              cursor;
  logic                     ahead;
  logic [15:0]              window;

  out_item_t   expected_results [EXP_DEPTH];
  int unsigned exp_rd     = 0;
  int unsigned exp_wr     = 0;
  int          mismatches = 0;

  function automatic logic [SLOT_W-1:0] slot_at(int unsigned i);
    return SLOT_W'((ring_base + i) % HISTORY_DEPTH);
  endfunction

  function automatic bit tail_merges(logic [31:0] key, logic [31:0] now);
    logic [31:0]       gap;
    logic [SLOT_W-1:0] t;
    if (key == '0 || n_entries == 0) return 1'b0;
    t = slot_at(n_entries - 1);
    gap = now - stamp_mem[t];
    return (key_mem[t] == key) && (gap <= {16'h0, window});
  endfunction

  task automatic push_entry(input in_item_t it);
    logic [SLOT_W-1:0] s;
    if (n_entries >= HISTORY_DEPTH) begin
      ring_base = (ring_base + 1) % HISTORY_DEPTH;
      n_entries = HISTORY_DEPTH - 1;
    end
    s = slot_at(n_entries);
    snap_mem[s]   = it.snapshot_ref;
    sel_mem[s]    = it.selected_index;
    key_mem[s]    = it.coalesce_key;
    stamp_mem[s]  = it.now_ticks;
    saved_mark[s] = 1'b0;
    n_entries++;
    cursor = n_entries;
  endtask

  task automatic apply_history_command(input in_item_t it, output out_item_t res);
    logic [SLOT_W-1:0] s;
    res = '0;
    case (op_t'(it.command))
      OP_CAPTURE: begin
        if (!it.suspended) begin
          ahead = 1'b1;
          if (cursor < n_entries) n_entries = cursor;
          if (tail_merges(it.coalesce_key, it.now_ticks)) begin
            s = slot_at(n_entries - 1);
            snap_mem[s]   = it.snapshot_ref;
            sel_mem[s]    = it.selected_index;
            stamp_mem[s]  = it.now_ticks;
            saved_mark[s] = 1'b0;
          end else begin
            push_entry(it);
            res.accepted = 1'b1;
          end
        end
      end
      OP_PRECAP: begin
        if (!it.suspended) begin
          ahead = 1'b1;
          if (cursor == n_entries && tail_merges(it.coalesce_key, it.now_ticks)) begin
            stamp_mem[slot_at(n_entries - 1)] = it.now_ticks;
          end else begin
            if (cursor < n_entries) n_entries = cursor;
            push_entry(it);
            res.accepted = 1'b1;
          end
        end
      end
      OP_UNDO: begin
        if (cursor >= UNDO_MIN_CURSOR && cursor <= n_entries) begin
          ahead = 1'b0;
          cursor--;
          s = slot_at(cursor - 1);
          res.restored_ref   = snap_mem[s];
          res.restored_index = sel_mem[s];
          res.accepted       = 1'b1;
        end
      end
      OP_REDO: begin
        if (cursor < n_entries) begin
          ahead = 1'b0;
          s = slot_at(cursor);
          cursor++;
          res.restored_ref   = snap_mem[s];
          res.restored_index = sel_mem[s];
          res.accepted       = 1'b1;
        end
      end
      OP_CLEAR: begin
        n_entries  = 0;
        cursor     = 0;
        ring_base  = 0;
        ahead      = 1'b0;
        saved_mark = '0;
      end
      OP_MARK: begin
        if (n_entries != 0) begin
          saved_mark = '0;
          if (cursor > 0 && cursor <= n_entries) saved_mark[slot_at(cursor - 1)] = 1'b1;
        end
      end
      default: ;
    endcase
    res.can_undo   = cursor >= UNDO_MIN_CURSOR;
    res.can_redo   = cursor < n_entries;
    res.at_saved   = cursor > 0 && cursor <= n_entries && saved_mark[slot_at(cursor - 1)];
    res.live_ahead = ahead;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      saved_mark = '0;
      ring_base  = 0;
      n_entries  = 0;
      cursor     = 0;
      ahead      = 1'b0;
      window     = WINDOW_RESET;
      foreach (snap_mem[i]) begin
        snap_mem[i]  = '0;
        sel_mem[i]   = '0;
        key_mem[i]   = '0;
        stamp_mem[i] = '0;
      end
      exp_rd = 0;
      exp_wr = 0;
    end else begin
      if (cfg_we) window = cfg_wdata;
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          $display("%0t ns: result with none expected, actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = expected_results[exp_rd % EXP_DEPTH];
          exp_rd++;
          check_field("accepted",       32'(want.accepted),       32'(out_data.accepted));
          check_field("restored_ref",   want.restored_ref,        out_data.restored_ref);
          check_field("restored_index", 32'(want.restored_index), 32'(out_data.restored_index));
          check_field("can_undo",       32'(want.can_undo),       32'(out_data.can_undo));
          check_field("can_redo",       32'(want.can_redo),       32'(out_data.can_redo));
          check_field("at_saved",       32'(want.at_saved),       32'(out_data.at_saved));
          check_field("live_ahead",     32'(want.live_ahead),     32'(out_data.live_ahead));
        end
      end
      if (in_valid && in_ready) begin
        apply_history_command(in_data, want);
        expected_results[exp_wr % EXP_DEPTH] = want;
        exp_wr++;
      end
    end
    pending_count <= int'(exp_wr - exp_rd);
    fail_count    <= mismatches;
  end

endmodule

>>> test/undo_redo_history_buffer_tb.sv
// Testbench top for the undo/redo history buffer: clock, reset, command stimulus,
// result-side stalls, window writes and the verdict.
// Depends on urhb_pkg, undo_redo_history_buffer and urhb_history_checker.
`timescale 1ns / 1ps

module undo_redo_history_buffer_tb import urhb_pkg::*; ();

  localparam logic [2:0] CMD_SPARE   = 3'd7;
  localparam int         STALL_LIMIT = 2000;
  localparam int         LONG_HOLD   = 300;
  localparam int         SETTLE      = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending_count;

  int          send_idle_pct = 0;
  int          rx_stall_pct  = 0;
  int          hold_reqs     = 0;
  logic [31:0] tick_now      = '0;
  logic [31:0] last_key      = 32'h1;
  logic [15:0] win_now       = WINDOW_RESET;
  int          stall_cycles  = 0;

  always #2 clk = ~clk;

  undo_redo_history_buffer DUT (
    .clk,
    .rst,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .cfg_we,
    .cfg_wdata
  );

  urhb_history_checker u_history_check (
    .clk,
    .rst,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .cfg_we,
    .cfg_wdata,
    .fail_count,
    .pending_count
  );

  function automatic in_item_t cmd_item(logic [2:0] cmd, logic [31:0] snap, logic [15:0] sel,
                                        logic [31:0] key, logic [31:0] now, logic susp);
    in_item_t it;
    it.command        = cmd;
    it.snapshot_ref   = snap;
    it.selected_index = sel;
    it.coalesce_key   = key;
    it.now_ticks      = now;
    it.suspended      = susp;
    return it;
  endfunction

  function automatic in_item_t random_command(bit fill);
    int          r;
    int          k;
    logic [2:0]  cmd;
    logic [31:0] key;
    r = $urandom_range(0, 99);
    if (fill) begin
      if (r < 70)      cmd = OP_CAPTURE;
      else if (r < 78) cmd = OP_PRECAP;
      else if (r < 86) cmd = OP_UNDO;
      else if (r < 90) cmd = OP_REDO;
      else if (r < 95) cmd = OP_MARK;
      else if (r < 98) cmd = OP_STATUS;
      else             cmd = CMD_SPARE;
    end else begin
      if (r < 30)      cmd = OP_CAPTURE;
      else if (r < 42) cmd = OP_PRECAP;
      else if (r < 62) cmd = OP_UNDO;
      else if (r < 77) cmd = OP_REDO;
      else if (r < 80) cmd = OP_CLEAR;
      else if (r < 88) cmd = OP_MARK;
      else if (r < 94) cmd = OP_STATUS;
      else             cmd = CMD_SPARE;
    end
    r = $urandom_range(0, 99);
    if (r < 60)
      tick_now += $urandom_range(0, int'(win_now) + int'(win_now) / 8 + 2);
    else if (r >= 80 && r < 95)
      tick_now += win_now + $urandom_range(0, 2);
    else if (r >= 95)
      tick_now = $urandom();
    k = $urandom_range(0, 9);
    if (k < (fill ? 7 : 3)) key = '0;
    else if (k < 7)         key = last_key;
    else if (k == 7)        key = $urandom();
    else if (k == 8)        key = 32'hFFFF_FFFF;
    else                    key = 32'h1;
    if (key != '0) last_key = key;
    return cmd_item(cmd, $urandom(), 16'($urandom_range(0, 65535)), key, tick_now,
                    $urandom_range(0, 9) == 0);
  endfunction

  task automatic send_cmd(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_window(input logic [15:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    win_now   = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic run_phase(input int n, input int send_pct, input int rx_pct,
                           input bit fill, input bit hold);
    send_idle_pct = send_pct;
    rx_stall_pct  = rx_pct;
    if (hold) hold_reqs++;
    repeat (n) send_cmd(random_command(fill));
    drain();
  endtask

  // result side: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    int hold_seen;
    bit ready_next;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_left = LONG_HOLD;
        hold_seen = hold_reqs;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = $urandom_range(0, 99) >= rx_stall_pct;
      end
      @(negedge clk);
      out_ready = ready_next;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: empty history, key and window edges, saved marks, tick wrap
    send_cmd(cmd_item(OP_STATUS,  '0, '0, '0, '0, 1'b0));
    send_cmd(cmd_item(CMD_SPARE,  '0, '0, '0, '0, 1'b0));
    send_cmd(cmd_item(OP_UNDO,    '0, '0, '0, '0, 1'b0));
    send_cmd(cmd_item(OP_REDO,    '0, '0, '0, '0, 1'b0));
    send_cmd(cmd_item(OP_MARK,    '0, '0, '0, '0, 1'b0));
    send_cmd(cmd_item(OP_CAPTURE, 32'h1234_5678, 16'h0001, 32'h1, 32'd0, 1'b1));
    send_cmd(cmd_item(OP_PRECAP,  32'h1234_5678, 16'h0001, 32'h1, 32'd0, 1'b1));
    send_cmd(cmd_item(OP_CAPTURE, 32'hFFFF_FFFF, 16'hFFFF, '0, 32'd0, 1'b0));
    send_cmd(cmd_item(OP_CAPTURE, '0, '0, '0, 32'd0, 1'b0));
    send_cmd(cmd_item(OP_CAPTURE, 32'h1111_1111, 16'h0011, 32'hFFFF_FFFF, 32'd10, 1'b0));
    send_cmd(cmd_item(OP_CAPTURE, 32'h2222_2222, 16'h0022, 32'hFFFF_FFFF, 32'd510, 1'b0));
    send_cmd(cmd_item(OP_CAPTURE, 32'h3333_3333, 16'h0033, 32'hFFFF_FFFF, 32'd1011, 1'b0));
    send_cmd(cmd_item(OP_PRECAP,  32'h4444_4444, 16'h0044, 32'hFFFF_FFFF, 32'd1100, 1'b0));
    send_cmd(cmd_item(OP_PRECAP,  32'h5555_5555, 16'h0055, 32'h2, 32'd1200, 1'b0));
    send_cmd(cmd_item(OP_MARK,    '0, '0, '0, 32'd1250, 1'b0));
    send_cmd(cmd_item(OP_CAPTURE, 32'h6666_6666, 16'h0066, 32'h2, 32'd1300, 1'b0));
    send_cmd(cmd_item(OP_MARK,    '0, '0, '0, 32'd1310, 1'b0));
    send_cmd(cmd_item(OP_UNDO,    '0, '0, '0, 32'd1320, 1'b0));
    send_cmd(cmd_item(OP_UNDO,    '0, '0, '0, 32'd1330, 1'b0));
    send_cmd(cmd_item(OP_REDO,    '0, '0, '0, 32'd1340, 1'b0));
    send_cmd(cmd_item(OP_PRECAP,  32'h7777_7777, 16'h0077, 32'h2, 32'd1400, 1'b0));
    send_cmd(cmd_item(OP_CAPTURE, 32'h8888_8888, 16'h0088, 32'h3, 32'hFFFF_FF00, 1'b0));
    send_cmd(cmd_item(OP_CAPTURE, 32'h9999_9999, 16'h0099, 32'h3, 32'h0000_0010, 1'b0));
    send_cmd(cmd_item(OP_CLEAR,   '0, '0, '0, 32'h0000_0020, 1'b0));
    send_cmd(cmd_item(OP_UNDO,    '0, '0, '0, 32'h0000_0030, 1'b0));
    drain();

    write_window(16'hFFFF);
    run_phase(160, 0, 0, 1'b1, 1'b0);
    write_window(16'h0000);
    run_phase(150, 46, 0, 1'b0, 1'b0);
    write_window(WINDOW_RESET);
    run_phase(150, 0, 46, 1'b0, 1'b1);
    write_window(16'($urandom_range(0, 65535)));
    run_phase(160, 31, 31, 1'b0, 1'b0);
    write_window(16'h0001);
    run_phase(150, 0, 0, 1'b0, 1'b0);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/urhb_pkg.sv
hw/rtl/urhb_front.sv
hw/rtl/urhb_queue.sv
hw/rtl/urhb_back.sv
hw/rtl/undo_redo_history_buffer.sv
hw/rtl/urhb_checker.sv
test/urhb_history_checker.sv
test/undo_redo_history_buffer_tb.sv
